// ===== hw/rtl/sbm_irq_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial bank mapper package
// Request types, register select codes and reset constants shared by the
// mapper with its interval IRQ timer.
// ----------------------------------------------------------------------------
package sbm_irq_pkg;

  // Default width of the IRQ interval counter.
  localparam int unsigned CounterBitsDefault = 30;

  // Request kinds.
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdTick  = 1'b1;

  // Target register selected by address bits 14:13.
  localparam logic [1:0] SelControl = 2'd0;
  localparam logic [1:0] SelOuter   = 2'd1;
  localparam logic [1:0] SelUnused  = 2'd2;
  localparam logic [1:0] SelInner   = 2'd3;

  // Serial shifter commits on the fifth write.
  localparam logic [2:0] ShiftLast = 3'd4;

  // Reset and forced values.
  localparam logic [4:0] ControlReset = 5'h0C;
  localparam logic [3:0] BankLoReset  = 4'd0;
  localparam logic [3:0] BankHiReset  = 4'd1;
  localparam logic [3:0] BankTop      = 4'd15;

  // IRQ timeout base value and position of the DIP field.
  localparam logic [31:0] TimeoutBase  = 32'h2000_0000;
  localparam int unsigned DipShift     = 22;

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } sbm_in_t;

  typedef struct packed {
    logic [3:0] bank_low_window;
    logic [3:0] bank_high_window;
    logic [1:0] mirror_mode;
    logic       wram_enable;
    logic       irq_out;
  } sbm_out_t;

endpackage

// ===== hw/rtl/serial_bank_mapper_with_irq_timer_core.sv =====
// ----------------------------------------------------------------------------
// Serial bank mapper with interval IRQ timer
// Five-write serial register port, PRG bank and mirroring selection, and a
// DIP-selected interval timer that raises the board IRQ line.
// ----------------------------------------------------------------------------
// Each request updates the mapper state at the edge that accepts it, and
// its result (the bank, mirroring, RAM enable and IRQ levels after the
// request) sits in the output register from the next cycle on. A new
// request can be accepted in every cycle unless the previous result is still
// waiting to be taken while out_ready_i is low. The interval counter is
// CounterBits wide; the IRQ rises when it reaches
// 0x20000000 | (dip << 22) and stays up until an IRQ register write with
// bit 4 set.
module serial_bank_mapper_with_irq_timer_core #(
  parameter int unsigned CounterBits = sbm_irq_pkg::CounterBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sbm_irq_pkg::sbm_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sbm_irq_pkg::sbm_out_t out_data_o
);
  import sbm_irq_pkg::*;

  logic [3:0]             dip_q;
  logic [2:0]             shift_count_q, shift_count_d;
  logic [4:0]             shift_bits_q, shift_bits_d, bits_new;
  logic [4:0]             control_q, control_d;
  logic [4:0]             outer_q, outer_d;
  logic [4:0]             inner_q, inner_d;
  logic                   started_q, started_d;
  logic                   irq_hold_q, irq_hold_d;
  logic                   irq_level_q, irq_level_d;
  logic [CounterBits-1:0] tick_q, tick_d, tick_inc, target;
  logic [3:0]             bank_lo_q, bank_lo_d, bank_hi_q, bank_hi_d;
  logic [1:0]             mirror_q, mirror_d;
  logic                   wram_en_q, wram_en_d;
  logic                   do_pick;
  logic [1:0]             sel;
  logic                   accept;
  logic                   out_valid_q;
  sbm_out_t               out_q, out_d;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign sel        = in_data_i.addr[14:13];
  assign bits_new   = shift_bits_q | (5'(in_data_i.data[0]) << shift_count_q);
  assign tick_inc   = tick_q + CounterBits'(1);
  assign target     = CounterBits'(TimeoutBase) | (CounterBits'(dip_q) << DipShift);

  // Next mapper state for the accepted request.
  always_comb begin
    shift_count_d = shift_count_q;
    shift_bits_d  = shift_bits_q;
    control_d     = control_q;
    outer_d       = outer_q;
    inner_d       = inner_q;
    started_d     = started_q;
    irq_hold_d    = irq_hold_q;
    irq_level_d   = irq_level_q;
    tick_d        = tick_q;
    bank_lo_d     = bank_lo_q;
    bank_hi_d     = bank_hi_q;
    mirror_d      = mirror_q;
    wram_en_d     = wram_en_q;
    do_pick       = 1'b0;
    if (accept) begin
      if (in_data_i.cmd == CmdTick) begin
        // The interval counter runs while the IRQ is not held.
        if (!irq_hold_q) begin
          if (tick_inc == target) begin
            tick_d      = '0;
            irq_level_d = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
      end else if (in_data_i.data[7]) begin
        // Reset write clears the shifter and forces the control mode bits.
        control_d     = control_q | ControlReset;
        shift_count_d = '0;
        shift_bits_d  = '0;
      end else if (shift_count_q != ShiftLast) begin
        shift_count_d = shift_count_q + 3'd1;
        shift_bits_d  = bits_new;
      end else begin
        // Fifth write commits the assembled value.
        shift_count_d = '0;
        shift_bits_d  = '0;
        unique case (sel)
          SelControl: begin
            control_d = bits_new;
            mirror_d  = bits_new[1:0];
            do_pick   = 1'b1;
          end
          SelOuter: begin
            outer_d    = bits_new;
            irq_hold_d = bits_new[4];
            if (bits_new[4]) begin
              started_d   = 1'b1;
              tick_d      = '0;
              irq_level_d = 1'b0;
            end else begin
              bank_lo_d = BankLoReset;
              bank_hi_d = BankHiReset;
            end
            do_pick = 1'b1;
          end
          SelInner: begin
            inner_d   = bits_new;
            wram_en_d = !bits_new[4];
            do_pick   = 1'b1;
          end
          SelUnused: begin
          end
          default: begin
          end
        endcase
      end
    end

    // Bank selection from the updated registers, once started.
    if (do_pick && started_d) begin
      if (!outer_d[3]) begin
        bank_lo_d = {1'b0, outer_d[2:1], 1'b0};
        bank_hi_d = {1'b0, outer_d[2:1], 1'b1};
      end else if (!control_d[3]) begin
        bank_lo_d = {1'b1, inner_d[2:1], 1'b0};
        bank_hi_d = {1'b1, inner_d[2:1], 1'b1};
      end else if (!control_d[2]) begin
        bank_lo_d = 4'd8;
        bank_hi_d = {1'b1, inner_d[2:0]};
      end else begin
        bank_lo_d = {1'b1, inner_d[2:0]};
        bank_hi_d = BankTop;
      end
    end
  end

  // Result fields as seen after the request.
  always_comb begin
    out_d.bank_low_window  = bank_lo_d;
    out_d.bank_high_window = bank_hi_d;
    out_d.mirror_mode      = mirror_d;
    out_d.wram_enable      = wram_en_d;
    out_d.irq_out          = irq_level_d;
  end

  // Mapper state registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_q         <= '0;
      shift_count_q <= '0;
      shift_bits_q  <= '0;
      control_q     <= ControlReset;
      outer_q       <= '0;
      inner_q       <= '0;
      started_q     <= 1'b0;
      irq_hold_q    <= 1'b1;
      irq_level_q   <= 1'b0;
      tick_q        <= '0;
      bank_lo_q     <= BankLoReset;
      bank_hi_q     <= BankHiReset;
      mirror_q      <= '0;
      wram_en_q     <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        dip_q <= cfg_wdata_i;
      end
      shift_count_q <= shift_count_d;
      shift_bits_q  <= shift_bits_d;
      control_q     <= control_d;
      outer_q       <= outer_d;
      inner_q       <= inner_d;
      started_q     <= started_d;
      irq_hold_q    <= irq_hold_d;
      irq_level_q   <= irq_level_d;
      tick_q        <= tick_d;
      bank_lo_q     <= bank_lo_d;
      bank_hi_q     <= bank_hi_d;
      mirror_q      <= mirror_d;
      wram_en_q     <= wram_en_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== bench/serial_bank_mapper_with_irq_timer_core_tb.sv =====
// ----------------------------------------------------------------------------
// Serial bank mapper with IRQ timer testbench
// Drives CPU write and tick requests through the valid/ready input channel
// and checks every result against a cycle-free model of the mapper. A
// short table of directed requests runs first. Random serial sequences,
// reset-bit writes, tick bursts and broken sequences follow under several
// timer DIP settings. Both channels idle at random, and the output side
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module serial_bank_mapper_with_irq_timer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbm_irq_pkg::*;

  localparam int unsigned CntBits      = CounterBitsDefault;
  localparam int unsigned RandPerPhase = 285;
  localparam int unsigned LongStall    = 160;
  localparam int unsigned IdleCycles   = 4;
  localparam int unsigned CycleLimit   = 400000;

  localparam sbm_out_t AfterReset = '{
    bank_low_window:  BankLoReset,
    bank_high_window: BankHiReset,
    mirror_mode:      2'd0,
    wram_enable:      1'b1,
    irq_out:          1'b0
  };

  typedef struct {
    sbm_in_t  req;
    bit       typed;
    sbm_out_t want;
  } dir_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  sbm_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  sbm_out_t out_data_o;

  // Mapper model state.
  logic [2:0]         sh_cnt;
  logic [4:0]         sh_bits;
  logic [4:0]         ctl_q, outer_q, inner_q;
  logic               started_q, hold_q, irq_q;
  logic [CntBits-1:0] ticks_q;
  logic [3:0]         bank_lo_q, bank_hi_q;
  logic [1:0]         mirror_q;
  logic               wram_q;
  logic [3:0]         dip_q;

  // Results still owed by the block, oldest first.
  sbm_out_t expected_maps[$];

  int unsigned n_errors    = 0;
  int unsigned n_results   = 0;
  int unsigned n_requests  = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_commits   = 0;
  int unsigned n_settings  = 0;
  int unsigned n_stalls    = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_cnt   = 0;

  serial_bank_mapper_with_irq_timer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock with a 10 ns period.
  always #5 clk_i = ~clk_i;

  // Run limit in case the block stops answering.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Clear the model to its power-up state.
  task automatic map_reset();
    sh_cnt    = '0;
    sh_bits   = '0;
    ctl_q     = ControlReset;
    outer_q   = '0;
    inner_q   = '0;
    started_q = 1'b0;
    hold_q    = 1'b1;
    irq_q     = 1'b0;
    ticks_q   = '0;
    bank_lo_q = BankLoReset;
    bank_hi_q = BankHiReset;
    mirror_q  = 2'd0;
    wram_q    = 1'b1;
    dip_q     = '0;
  endtask

  // Derive the two 16K windows; nothing moves before the first IRQ enable.
  function automatic void pick_windows();
    if (!started_q) return;
    if (!outer_q[3]) begin
      bank_lo_q = {1'b0, outer_q[2:1], 1'b0};
      bank_hi_q = {1'b0, outer_q[2:1], 1'b1};
    end else if (!ctl_q[3]) begin
      bank_lo_q = {1'b1, inner_q[2:1], 1'b0};
      bank_hi_q = {1'b1, inner_q[2:1], 1'b1};
    end else if (!ctl_q[2]) begin
      bank_lo_q = 4'd8;
      bank_hi_q = {1'b1, inner_q[2:0]};
    end else begin
      bank_lo_q = {1'b1, inner_q[2:0]};
      bank_hi_q = BankTop;
    end
  endfunction

  // Apply one request to the model and return the outputs after it.
  function automatic sbm_out_t map_request(sbm_in_t req);
    logic [4:0]         val;
    logic [31:0]        wide_limit;
    logic [CntBits-1:0] limit;
    if (req.cmd == CmdTick) begin
      // The counter only runs while the hold is released.
      if (!hold_q) begin
        wide_limit = TimeoutBase | (32'(dip_q) << DipShift);
        limit      = wide_limit[CntBits-1:0];
        ticks_q    = ticks_q + 1'b1;
        if (ticks_q == limit) begin
          ticks_q = '0;
          irq_q   = 1'b1;
        end
      end
    end else if (req.data[7]) begin
      // Reset-bit write: clear the shifter and force the PRG mode bits.
      ctl_q   = ctl_q | ControlReset;
      sh_cnt  = '0;
      sh_bits = '0;
    end else begin
      if (req.data[0]) sh_bits[sh_cnt] = 1'b1;
      if (sh_cnt != ShiftLast) begin
        sh_cnt = sh_cnt + 1'b1;
      end else begin
        // Fifth write commits to the register picked by address bits 14:13.
        val     = sh_bits;
        sh_cnt  = '0;
        sh_bits = '0;
        n_commits++;
        case (req.addr[14:13])
          SelControl: begin
            ctl_q = val;
            pick_windows();
            mirror_q = val[1:0];
          end
          SelOuter: begin
            outer_q = val;
            hold_q  = val[4];
            if (val[4]) begin
              started_q = 1'b1;
              ticks_q   = '0;
              irq_q     = 1'b0;
            end else begin
              bank_lo_q = BankLoReset;
              bank_hi_q = BankHiReset;
            end
            pick_windows();
          end
          SelInner: begin
            inner_q = val;
            wram_q  = !val[4];
            pick_windows();
          end
          default: ;
        endcase
      end
    end
    return '{bank_low_window: bank_lo_q, bank_high_window: bank_hi_q,
             mirror_mode: mirror_q, wram_enable: wram_q, irq_out: irq_q};
  endfunction

  function automatic dir_row_t mk_row(logic cmd, logic [15:0] addr, logic [7:0] data,
                                      bit typed = 1'b0, sbm_out_t want = '0);
    dir_row_t r;
    r.req   = '{cmd: cmd, addr: addr, data: data};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Offer one request in bursts with random gaps, then log its result.
  task automatic send_req(sbm_in_t req, bit typed = 1'b0, sbm_out_t want = '0);
    int unsigned gap;
    sbm_out_t    model_out;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    model_out = map_request(req);
    expected_maps.push_back(typed ? want : model_out);
    n_requests++;
    if (req.cmd == CmdTick) n_ticks++;
  endtask

  function automatic sbm_in_t tick_req();
    return '{cmd: CmdTick, addr: 16'($urandom), data: 8'($urandom)};
  endfunction

  function automatic sbm_in_t write_req(logic [15:0] addr, logic bit0);
    return '{cmd: CmdWrite, addr: addr, data: {1'b0, 6'($urandom), bit0}};
  endfunction

  // Five serial writes of a random value, with ticks sometimes in between.
  task automatic send_commit(logic [1:0] sel, logic [4:0] val);
    logic [15:0] addr;
    for (int i = 0; i < 5; i++) begin
      addr = {1'($urandom), sel, 13'($urandom)};
      if ($urandom_range(0, 4) == 0) send_req(tick_req());
      send_req(write_req(addr, val[i]));
    end
  endtask

  // Stop offering and wait until every result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_dip(logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dip_q = value;
    n_settings++;
  endtask

  // Output checker: compare every taken result with the oldest expectation.
  always @(negedge clk_i) begin
    sbm_out_t want;
    sbm_out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      n_results++;
      if (expected_maps.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        n_errors++;
      end else begin
        want = expected_maps.pop_front();
        if (got.bank_low_window !== want.bank_low_window) begin
          $error("bank_low_window: expected %0d, got %0d",
                 want.bank_low_window, got.bank_low_window);
          n_errors++;
        end
        if (got.bank_high_window !== want.bank_high_window) begin
          $error("bank_high_window: expected %0d, got %0d",
                 want.bank_high_window, got.bank_high_window);
          n_errors++;
        end
        if (got.mirror_mode !== want.mirror_mode) begin
          $error("mirror_mode: expected %0d, got %0d", want.mirror_mode, got.mirror_mode);
          n_errors++;
        end
        if (got.wram_enable !== want.wram_enable) begin
          $error("wram_enable: expected %0d, got %0d", want.wram_enable, got.wram_enable);
          n_errors++;
        end
        if (got.irq_out !== want.irq_out) begin
          $error("irq_out: expected %0d, got %0d", want.irq_out, got.irq_out);
          n_errors++;
        end
      end
    end
  end

  // Output side: stall patterns that change over time, plus long hold-offs.
  initial begin
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned pressure_mark;
    int unsigned phase;
    hold_left     = 0;
    mode          = 0;
    mode_left     = 0;
    pressure_mark = 200;
    phase         = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && n_results >= pressure_mark) begin
        hold_left = LongStall;
        pressure_mark += 600;
        n_stalls++;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= (phase % 5 < 3);
        endcase
      end
    end
  end

  // Stimulus: directed table, then random phases under several DIP settings.
  initial begin
    dir_row_t    rows[$];
    logic [3:0]  dips[5];
    int unsigned sent;
    int unsigned pick;
    int unsigned len;

    // Power-up and hold-off checks first, then a commit to every register.
    rows.push_back(mk_row(CmdTick,  16'h0000, 8'h00, 1'b1, AfterReset));
    rows.push_back(mk_row(CmdWrite, 16'h8000, 8'hFF, 1'b1, AfterReset));
    // IRQ register 0x18: hold and start, windows move to the second chip.
    rows.push_back(mk_row(CmdWrite, 16'hBFFF, 8'h00));
    rows.push_back(mk_row(CmdWrite, 16'hBFFF, 8'h7E));
    rows.push_back(mk_row(CmdWrite, 16'hBFFF, 8'h00));
    rows.push_back(mk_row(CmdWrite, 16'hBFFF, 8'h01));
    rows.push_back(mk_row(CmdWrite, 16'hBFFF, 8'h7F));
    // Control 0x0B from an address below $8000: fixed low window, mirroring 3.
    rows.push_back(mk_row(CmdWrite, 16'h1FFF, 8'h01));
    rows.push_back(mk_row(CmdWrite, 16'h1FFF, 8'h7F));
    rows.push_back(mk_row(CmdWrite, 16'h1FFF, 8'h40));
    rows.push_back(mk_row(CmdWrite, 16'h1FFF, 8'h03));
    rows.push_back(mk_row(CmdWrite, 16'h1FFF, 8'h00));
    // Inner 0x1F: RAM off, bank bit 3 must be ignored.
    rows.push_back(mk_row(CmdWrite, 16'hFFFF, 8'h7F));
    rows.push_back(mk_row(CmdWrite, 16'hFFFF, 8'h55));
    rows.push_back(mk_row(CmdWrite, 16'hFFFF, 8'h33));
    rows.push_back(mk_row(CmdWrite, 16'hFFFF, 8'h0F));
    rows.push_back(mk_row(CmdWrite, 16'hFFFF, 8'h01));
    // Unused register: the commit only clears the shifter.
    rows.push_back(mk_row(CmdWrite, 16'hC000, 8'h01));
    rows.push_back(mk_row(CmdWrite, 16'hC000, 8'h01));
    rows.push_back(mk_row(CmdWrite, 16'hC000, 8'h00));
    rows.push_back(mk_row(CmdWrite, 16'hC000, 8'h01));
    rows.push_back(mk_row(CmdWrite, 16'hC000, 8'h01));
    // IRQ register 0x00: release the hold, windows back to 0 and 1.
    rows.push_back(mk_row(CmdWrite, 16'hA000, 8'h00));
    rows.push_back(mk_row(CmdWrite, 16'hA000, 8'h02));
    rows.push_back(mk_row(CmdWrite, 16'hA000, 8'h04));
    rows.push_back(mk_row(CmdWrite, 16'hA000, 8'h08));
    rows.push_back(mk_row(CmdWrite, 16'hA000, 8'h10));
    rows.push_back(mk_row(CmdTick,  16'hFFFF, 8'hFF));

    dips[0] = 4'd0;
    dips[1] = 4'd15;
    dips[2] = 4'($urandom);
    dips[3] = 4'($urandom);
    dips[4] = 4'd8;

    map_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < 5; p++) begin
      write_dip(dips[p]);
      if (p == 0) begin
        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].want);
      end
      sent = n_requests;
      while (n_requests - sent < RandPerPhase) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_commit(2'($urandom), 5'($urandom));
        end else if (pick < 75) begin
          len = $urandom_range(1, 20);
          repeat (len) send_req(tick_req());
        end else if (pick < 85) begin
          send_req('{cmd: CmdWrite, addr: 16'($urandom), data: {1'b1, 7'($urandom)}});
        end else begin
          // Broken sequence: one to four serial writes, too few to commit on their own.
          len = $urandom_range(1, 4);
          repeat (len) send_req('{cmd: CmdWrite, addr: 16'($urandom),
                                  data: {1'b0, 7'($urandom)}});
        end
      end
      wait_idle();
    end

    $display("Run covered %0d requests (%0d ticks, %0d register commits) over %0d DIP settings,",
             n_requests, n_ticks, n_commits, n_settings);
    $display("with %0d long output stalls and %0d results checked.", n_stalls, n_results);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== serial_bank_mapper_with_irq_timer_core.f =====
hw/rtl/sbm_irq_pkg.sv
hw/rtl/serial_bank_mapper_with_irq_timer_core.sv
bench/serial_bank_mapper_with_irq_timer_core_tb.sv
